### src/rth_pkg.sv
`timescale 1ns / 1ps
// Package for the RGB to HLS pixel converter: field widths, fixed-point
// formats, the item types passed between stages and the divider step.
// Depends on nothing; every other file of the block imports it.

package rth_pkg;

   // Fixed-point formats of the results.
   localparam int unsigned FRAC_BITS     = 16;
   localparam int unsigned HUE_FRAC_BITS = 6;

   // Field widths.
   localparam int unsigned CH_W  = 8;
   localparam int unsigned HUE_W = 15;
   localparam int unsigned LS_W  = 17;

   // Intermediate widths: channel sum, divisor, hue term and hue numerator.
   localparam int unsigned SUM_W = CH_W + 1;
   localparam int unsigned DEN_W = CH_W + 1;
   localparam int unsigned T_W   = CH_W + 3;
   localparam int unsigned NUM_W = 17;

   // The full range of max plus min, and its half.
   localparam logic [DEN_W-1:0] LIGHT_DEN = DEN_W'(510);
   localparam logic [SUM_W-1:0] HALF_SUM  = SUM_W'(255);

   // Lightness rounded to nearest is (s * 2^(FRAC_BITS-1) + 127) / 255 rounded
   // down. The division by 255 is a multiply by its reciprocal scaled up by
   // 2^(LM_W+8) and rounded up, which is exact for every LM_W-bit dividend.
   localparam int unsigned LM_W     = SUM_W + FRAC_BITS - 1;
   localparam int unsigned RECIP_SH = LM_W + 8;
   localparam int unsigned RECIP_W  = LM_W + 1;
   localparam int unsigned LP_W     = LM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] LIGHT_RECIP =
      RECIP_W'(((64'd1 << RECIP_SH) / 64'd255) + 64'd1);
   localparam logic [LM_W-1:0]    LIGHT_BIAS  = LM_W'(127);

   // Dividend widths. One extra fraction bit is kept for rounding.
   localparam int unsigned LS_DIV_W  = SUM_W + FRAC_BITS + 1;
   localparam int unsigned HUE_DIV_W = NUM_W + HUE_FRAC_BITS + 1;
   localparam int unsigned DIV_W     = (LS_DIV_W > HUE_DIV_W) ? LS_DIV_W : HUE_DIV_W;

   // Quotient widths: ratios up to 1 for saturation, up to 360 for hue, each
   // with one rounding bit below the result.
   localparam int unsigned LS_QW  = FRAC_BITS + 2;
   localparam int unsigned HUE_QW = HUE_FRAC_BITS + 10;
   localparam int unsigned QW     = (LS_QW > HUE_QW) ? LS_QW : HUE_QW;

   // Width of the shifted divisor in a trial subtraction.
   localparam int unsigned SH_W = DIV_W + DEN_W;

   // Channel that holds the maximum; red wins ties, then green.
   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   // One division in flight: partial remainder, divisor and quotient so far.
   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QW-1:0]    quo;
   } div_lane_type;

   // An item inside the divider: two divisions, the finished lightness and
   // the grey flag.
   typedef struct packed {
      div_lane_type    hue;
      div_lane_type    sat;
      logic [LS_W-1:0] light;
      logic            grey;
   } div_item_type;

   // One restoring division step that decides quotient bit bit_idx.
   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input int unsigned  bit_idx);
      div_lane_type    res;
      logic [SH_W-1:0] trial;
      logic [SH_W-1:0] part;
      res   = lane;
      trial = SH_W'(lane.den) << bit_idx;
      part  = SH_W'(lane.rem);
      if (part >= trial) begin
         res.rem = lane.rem - trial[DIV_W-1:0];
         res.quo = lane.quo | (QW'(1) << bit_idx);
      end
      return res;
   endfunction

endpackage

### src/rth_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the RGB to HLS pixel converter: the pixel request
// channel and the HLS response channel. Depends on rth_pkg.

interface rth_req_if;
   import rth_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_rsp_if;
   import rth_pkg::*;

   logic             valid;
   logic             ready;
   logic [HUE_W-1:0] hue_deg;
   logic [LS_W-1:0]  lightness;
   logic [LS_W-1:0]  saturation;

   modport source (output valid, output hue_deg, output lightness, output saturation,
                   input ready);
   modport sink   (input valid, input hue_deg, input lightness, input saturation,
                   output ready);
endinterface

### src/rth_prep.sv
`timescale 1ns / 1ps
// Front end of the converter: three stages that find max and min, form the
// hue numerator with its wrap, work out the lightness and set up the hue and
// saturation divisions. Uses rth_pkg.

module rth_prep (
   input  logic                 clock,
   input  logic                 reset,
   rth_req_if.sink              req_ch,
   output rth_pkg::div_item_type out_data,
   output logic                 out_valid,
   input  logic                 out_ready
);
   import rth_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0]  d;
      logic [SUM_W-1:0] s;
      logic [T_W-1:0]   t;
   } st1_type;

   typedef struct packed {
      logic [CH_W-1:0]  d;
      logic [LS_W-1:0]  light;
      logic [DEN_W-1:0] sat_den;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] d360;
   } st2_type;

   st1_type      s1_ff, s1_in;
   st2_type      s2_ff, s2_in;
   div_item_type s3_ff, s3_in;
   logic         v1_ff, v2_ff, v3_ff;
   logic         adv1, adv2, adv3;

   // A stage moves when it is empty or its successor moves.
   assign adv3         = !v3_ff || out_ready;
   assign adv2         = !v2_ff || adv3;
   assign adv1         = !v1_ff || adv2;
   assign req_ch.ready = adv1;
   assign out_valid    = v3_ff;
   assign out_data     = s3_ff;

   // Stage one: largest and smallest channel, range, sum and the hue term.
   always_comb begin
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] mn;
      logic [CH_W-1:0] d;
      max_sel_type     sel;
      mx = req_ch.red;
      mn = req_ch.red;
      if (req_ch.green > mx) mx = req_ch.green;
      if (req_ch.blue > mx)  mx = req_ch.blue;
      if (req_ch.green < mn) mn = req_ch.green;
      if (req_ch.blue < mn)  mn = req_ch.blue;
      d = mx - mn;
      if (req_ch.red == mx) begin
         sel = MAX_RED;
      end else if (req_ch.green == mx) begin
         sel = MAX_GREEN;
      end else begin
         sel = MAX_BLUE;
      end
      s1_in.d = d;
      s1_in.s = SUM_W'(mx) + SUM_W'(mn);
      // The term is never negative, so modular arithmetic gives it exactly.
      case (sel)
         MAX_RED: begin
            s1_in.t = (T_W'(d) << 2) + (T_W'(d) << 1) + T_W'(req_ch.green)
                      - T_W'(req_ch.blue);
         end
         MAX_GREEN: begin
            s1_in.t = (T_W'(d) << 1) + T_W'(req_ch.blue) - T_W'(req_ch.red);
         end
         MAX_BLUE: begin
            s1_in.t = (T_W'(d) << 2) + T_W'(req_ch.red) - T_W'(req_ch.green);
         end
         default: begin
            s1_in.t = '0;
         end
      endcase
   end

   // Stage two: scale the term by 60, form 360 times the range, pick the
   // saturation divisor from the side of one half that the lightness is on,
   // and divide the sum by 510 through the reciprocal of 255.
   always_comb begin
      logic [LM_W-1:0] light_num;
      logic [LP_W-1:0] light_prod;
      light_num     = (LM_W'(s1_ff.s) << (FRAC_BITS - 1)) + LIGHT_BIAS;
      light_prod    = LP_W'(light_num) * LP_W'(LIGHT_RECIP);
      s2_in.d       = s1_ff.d;
      s2_in.light   = LS_W'(light_prod >> RECIP_SH);
      s2_in.num     = (NUM_W'(s1_ff.t) << 6) - (NUM_W'(s1_ff.t) << 2);
      s2_in.d360    = (NUM_W'(s1_ff.d) << 8) + (NUM_W'(s1_ff.d) << 6)
                      + (NUM_W'(s1_ff.d) << 5) + (NUM_W'(s1_ff.d) << 3);
      s2_in.sat_den = (s1_ff.s <= HALF_SUM) ? DEN_W'(s1_ff.s) : (LIGHT_DEN - DEN_W'(s1_ff.s));
   end

   // Stage three: wrap hues above 360 and load the two dividends.
   always_comb begin
      logic [NUM_W-1:0] wrapped;
      wrapped = (s2_ff.num > s2_ff.d360) ? (s2_ff.num - s2_ff.d360) : s2_ff.num;
      s3_in.hue.rem   = DIV_W'(wrapped) << (HUE_FRAC_BITS + 1);
      s3_in.hue.den   = DEN_W'(s2_ff.d);
      s3_in.hue.quo   = '0;
      s3_in.sat.rem   = DIV_W'(s2_ff.d) << (FRAC_BITS + 1);
      s3_in.sat.den   = s2_ff.sat_den;
      s3_in.sat.quo   = '0;
      s3_in.light     = s2_ff.light;
      s3_in.grey      = (s2_ff.d == '0);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_ch.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
      if (adv3) s3_ff <= s3_in;
   end

endmodule

### src/rth_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider of the converter: one stage per quotient bit,
// hue and saturation divided side by side, lightness carried along. Uses rth_pkg.

module rth_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rth_pkg::div_item_type in_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   output rth_pkg::div_item_type out_data,
   output logic                  out_valid,
   input  logic                  out_ready
);
   import rth_pkg::*;

   div_item_type stage_ff [QW];
   logic         valid_ff [QW];
   logic         adv      [QW];

   assign in_ready  = adv[0];
   assign out_data  = stage_ff[QW-1];
   assign out_valid = valid_ff[QW-1];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      div_item_type src;
      div_item_type stage_in;
      logic         src_valid;

      // Each stage takes the item of the stage before it.
      if (i == 0) begin : g_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = stage_ff[i-1];
         assign src_valid = valid_ff[i-1];
      end

      // A stage moves when it is empty or its successor moves.
      if (i == QW - 1) begin : g_last
         assign adv[i] = !valid_ff[i] || out_ready;
      end else begin : g_mid
         assign adv[i] = !valid_ff[i] || adv[i+1];
      end

      // Decide one quotient bit, most significant first, in both lanes.
      always_comb begin
         stage_in     = src;
         stage_in.hue = div_step(src.hue, QW - 1 - i);
         stage_in.sat = div_step(src.sat, QW - 1 - i);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i]) stage_ff[i] <= stage_in;
      end
   end

endmodule

### src/rth_out.sv
`timescale 1ns / 1ps
// Output stage of the converter: rounds the quotients to nearest, clears hue
// and saturation of grey pixels and holds the result item. Uses rth_pkg.

module rth_out (
   input  logic                  clock,
   input  logic                  reset,
   input  rth_pkg::div_item_type in_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   rth_rsp_if.source             rsp_ch
);
   import rth_pkg::*;

   logic             valid_ff;
   logic [HUE_W-1:0] hue_ff, hue_in;
   logic [LS_W-1:0]  light_ff, light_in;
   logic [LS_W-1:0]  sat_ff, sat_in;

   // The quotient carries one extra bit; add a half and drop it.
   function automatic logic [QW-1:0] round_half(input logic [QW-1:0] q);
      logic [QW:0] sum;
      sum = {1'b0, q} + (QW + 1)'(1);
      return sum[QW:1];
   endfunction

   assign in_ready = !valid_ff || rsp_ch.ready;

   // Rounding and the grey-pixel rule; the lightness arrives already rounded.
   always_comb begin
      hue_in   = in_data.grey ? '0 : HUE_W'(round_half(in_data.hue.quo));
      sat_in   = in_data.grey ? '0 : LS_W'(round_half(in_data.sat.quo));
      light_in = in_data.light;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         hue_ff   <= hue_in;
         light_ff <= light_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.hue_deg    = hue_ff;
   assign rsp_ch.lightness  = light_ff;
   assign rsp_ch.saturation = sat_ff;

endmodule

### src/rgb_to_hls_pixel_converter.sv
`timescale 1ns / 1ps
// Top level of the RGB to HLS pixel converter: front end, pipelined divider
// and output stage. Depends on rth_pkg, rth_if, rth_prep, rth_div and rth_out.
//
//   Channel   Direction  Payload                                Handshake
//   req_ch    in         red, green, blue (8 bits each)         valid / ready
//   rsp_ch    out        hue_deg (15), lightness (17),          valid / ready
//                        saturation (17)
//
// One pixel is accepted every clock cycle while the output is not stalled;
// each pixel passes in order through three front-end stages, one divider
// stage for each of the 18 quotient bits and one output register.
// Reset is synchronous and clears only the valid bits.
// A stalled output halts only the full stages behind it: empty stages keep
// filling, so items are still accepted while a result waits to be taken and a stage is empty.

module rgb_to_hls_pixel_converter (
   input logic       clock,
   input logic       reset,
   rth_req_if.sink   req_ch,
   rth_rsp_if.source rsp_ch
);
   import rth_pkg::*;

   div_item_type prep_data;
   logic         prep_valid;
   logic         prep_ready;
   div_item_type div_data;
   logic         div_valid;
   logic         div_ready;

   // Max, min, hue numerator, lightness and divider set-up.
   rth_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_data  (prep_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready)
   );

   // Hue and saturation divisions, one quotient bit per stage.
   rth_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_data   (prep_data),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .out_data  (div_data),
      .out_valid (div_valid),
      .out_ready (div_ready)
   );

   // Rounding and the result register.
   rth_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_data  (div_data),
      .in_valid (div_valid),
      .in_ready (div_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule
